// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl files, used by the parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/id3w_pkg.sv =====
`timescale 1ns / 1ps

package id3w_pkg;

    // walker phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FRAME_HDR,
        PH_PAYLOAD,
        PH_NOTAG,
        PH_DONE,
        PH_STOPPED
    } t_phase;

    // status reported with every byte
    typedef enum logic [1:0] {
        ST_WALKING,
        ST_NO_TAG,
        ST_FINISHED,
        ST_STOPPED
    } t_status;

    // frame kinds
    typedef enum logic [3:0] {
        KIND_NONE,
        KIND_ARTIST,
        KIND_TITLE,
        KIND_ALBUM,
        KIND_TRACK,
        KIND_YEAR,
        KIND_COMMENT,
        KIND_GENRE,
        KIND_PICTURE
    } t_kind;

    // one result per input byte
    typedef struct packed {
        t_kind       frame_kind;
        logic        text_valid;
        logic [6:0]  text_byte;
        logic        frame_end;
        logic        picture_mark;
        logic [28:0] byte_offset;
        logic [7:0]  major_version;
        t_status     parse_status;
    } t_result;

    localparam logic [28:0] OFFSET_MAX = 29'd268435465;

    // tag header
    localparam logic [7:0] SIG_I = 8'h49;
    localparam logic [7:0] SIG_D = 8'h44;
    localparam logic [7:0] SIG_3 = 8'h33;
    localparam logic [7:0] VER_2 = 8'd2;
    localparam logic [7:0] VER_4 = 8'd4;

    // frame header geometry
    localparam logic [3:0] HDR_SIZE_V2 = 4'd6;
    localparam logic [3:0] HDR_SIZE_V3 = 4'd10;
    localparam logic [3:0] ID_LEN_V2   = 4'd3;
    localparam logic [3:0] ID_LEN_V3   = 4'd4;
    localparam logic [3:0] LEN_END_V2  = 4'd6;
    localparam logic [3:0] LEN_END_V3  = 4'd8;
    localparam logic [3:0] PIC_OFF_V2  = 4'd6;
    localparam logic [3:0] PIC_OFF_V3  = 4'd13;
    localparam logic [3:0] CNT_SAT     = 4'd15;

    localparam logic [7:0] TEXT_LOW = 8'h20;

    // version 2 frame ids
    localparam logic [31:0] ID_TP1 = {8'h00, "TP1"};
    localparam logic [31:0] ID_TT2 = {8'h00, "TT2"};
    localparam logic [31:0] ID_TAL = {8'h00, "TAL"};
    localparam logic [31:0] ID_TRK = {8'h00, "TRK"};
    localparam logic [31:0] ID_TYE = {8'h00, "TYE"};
    localparam logic [31:0] ID_COM = {8'h00, "COM"};
    localparam logic [31:0] ID_TCO = {8'h00, "TCO"};
    localparam logic [31:0] ID_PIC = {8'h00, "PIC"};

    // version 3 and 4 frame ids
    localparam logic [31:0] ID_TPE1 = "TPE1";
    localparam logic [31:0] ID_TIT2 = "TIT2";
    localparam logic [31:0] ID_TALB = "TALB";
    localparam logic [31:0] ID_TRCK = "TRCK";
    localparam logic [31:0] ID_TYER = "TYER";
    localparam logic [31:0] ID_COMM = "COMM";
    localparam logic [31:0] ID_APIC = "APIC";

    // map a frame id to its kind
    function automatic t_kind kind_of(input logic [7:0] version, input logic [31:0] id);
        t_kind k;
        k = KIND_NONE;
        if (version == VER_2) begin
            unique case (id)
                ID_TP1:  k = KIND_ARTIST;
                ID_TT2:  k = KIND_TITLE;
                ID_TAL:  k = KIND_ALBUM;
                ID_TRK:  k = KIND_TRACK;
                ID_TYE:  k = KIND_YEAR;
                ID_COM:  k = KIND_COMMENT;
                ID_TCO:  k = KIND_GENRE;
                ID_PIC:  k = KIND_PICTURE;
                default: k = KIND_NONE;
            endcase
        end else begin
            unique case (id)
                ID_TPE1: k = KIND_ARTIST;
                ID_TIT2: k = KIND_TITLE;
                ID_TALB: k = KIND_ALBUM;
                ID_TRCK: k = KIND_TRACK;
                ID_TYER: k = KIND_YEAR;
                ID_COMM: k = KIND_COMMENT;
                ID_APIC: k = KIND_PICTURE;
                default: k = KIND_NONE;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== hdl/id3w_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module id3w_parser
    import id3w_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data,
    input  logic       i_sof,
    output t_result    o_result
);

    t_phase      r_phase, n_phase, c_phase;
    logic [3:0]  r_field_count, n_field_count, c_field_count;
    logic [7:0]  r_tag_version, n_tag_version, c_tag_version;
    logic [27:0] r_tag_bytes_left, n_tag_bytes_left, c_tag_bytes_left;
    logic [31:0] r_frame_id, n_frame_id, c_frame_id;
    logic [31:0] r_frame_bytes_left, n_frame_bytes_left, c_frame_bytes_left;
    t_kind       r_kind, n_kind, c_kind;
    logic [28:0] r_position, n_position, c_position;

    logic [3:0]  hdr_size;
    logic [3:0]  id_len;
    logic [3:0]  len_end;
    logic [3:0]  pic_off;
    logic [3:0]  cnt_inc;
    logic [7:0]  sig_want;
    logic [27:0] tag_after_hdr;
    logic        at_boundary;

    // state registers, updated once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_HEADER;
            r_field_count      <= '0;
            r_tag_version      <= '0;
            r_tag_bytes_left   <= '0;
            r_frame_id         <= '0;
            r_frame_bytes_left <= '0;
            r_kind             <= KIND_NONE;
            r_position         <= '0;
        end else if (i_accept) begin
            r_phase            <= n_phase;
            r_field_count      <= n_field_count;
            r_tag_version      <= n_tag_version;
            r_tag_bytes_left   <= n_tag_bytes_left;
            r_frame_id         <= n_frame_id;
            r_frame_bytes_left <= n_frame_bytes_left;
            r_kind             <= n_kind;
            r_position         <= n_position;
        end
    end

    // next state and result for the byte on the input
    always_comb begin
        // start of file restarts the walk on this very byte
        if (i_sof) begin
            c_phase            = PH_HEADER;
            c_field_count      = '0;
            c_tag_version      = '0;
            c_tag_bytes_left   = '0;
            c_frame_id         = '0;
            c_frame_bytes_left = '0;
            c_kind             = KIND_NONE;
            c_position         = '0;
        end else begin
            c_phase            = r_phase;
            c_field_count      = r_field_count;
            c_tag_version      = r_tag_version;
            c_tag_bytes_left   = r_tag_bytes_left;
            c_frame_id         = r_frame_id;
            c_frame_bytes_left = r_frame_bytes_left;
            c_kind             = r_kind;
            c_position         = r_position;
        end

        n_phase            = c_phase;
        n_field_count      = c_field_count;
        n_tag_version      = c_tag_version;
        n_tag_bytes_left   = c_tag_bytes_left;
        n_frame_id         = c_frame_id;
        n_frame_bytes_left = c_frame_bytes_left;
        n_kind             = c_kind;

        // frame geometry for this version
        if (c_tag_version == VER_2) begin
            hdr_size = HDR_SIZE_V2;
            id_len   = ID_LEN_V2;
            len_end  = LEN_END_V2;
            pic_off  = PIC_OFF_V2;
        end else begin
            hdr_size = HDR_SIZE_V3;
            id_len   = ID_LEN_V3;
            len_end  = LEN_END_V3;
            pic_off  = PIC_OFF_V3;
        end

        priority if (c_position == 29'd0) begin
            sig_want = SIG_I;
        end else if (c_position == 29'd1) begin
            sig_want = SIG_D;
        end else begin
            sig_want = SIG_3;
        end

        cnt_inc       = c_field_count + 4'd1;
        tag_after_hdr = c_tag_bytes_left - {24'd0, hdr_size};
        at_boundary   = 1'b0;

        o_result              = '0;
        o_result.frame_kind   = KIND_NONE;
        o_result.byte_offset  = c_position;

        unique case (c_phase)
            // tag header: signature, version, flags, syncsafe size
            PH_HEADER: begin
                if (c_position < 29'd3) begin
                    if (i_data != sig_want) begin
                        n_phase = PH_NOTAG;
                    end
                end else if (c_position == 29'd3) begin
                    n_tag_version = i_data;
                    if (i_data < VER_2 || i_data > VER_4) begin
                        n_phase = PH_NOTAG;
                    end
                end else if (c_position >= 29'd6) begin
                    n_tag_bytes_left = {c_tag_bytes_left[20:0], i_data[6:0]};
                    if (c_position >= 29'd9) begin
                        at_boundary = 1'b1;
                    end
                end
            end

            // frame header: id, length, flags
            PH_FRAME_HDR: begin
                if (c_field_count < id_len) begin
                    if (c_field_count == 4'd0 && i_data == 8'd0) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_frame_id = {c_frame_id[23:0], i_data};
                    end
                end else if (c_field_count < len_end) begin
                    if (c_tag_version == VER_4) begin
                        n_frame_bytes_left = {c_frame_bytes_left[24:0], i_data[6:0]};
                    end else begin
                        n_frame_bytes_left = {c_frame_bytes_left[23:0], i_data};
                    end
                end
                if (n_phase == PH_FRAME_HDR) begin
                    n_field_count = cnt_inc;
                    if (cnt_inc >= hdr_size) begin
                        n_tag_bytes_left = tag_after_hdr;
                        if (n_frame_bytes_left == 32'd0 ||
                            n_frame_bytes_left > {4'd0, tag_after_hdr}) begin
                            n_phase = PH_STOPPED;
                        end else begin
                            n_tag_bytes_left = tag_after_hdr - n_frame_bytes_left[27:0];
                            n_kind           = kind_of(c_tag_version, n_frame_id);
                            n_phase          = PH_PAYLOAD;
                            n_field_count    = '0;
                        end
                    end
                end
            end

            // payload: text bytes, picture mark, frame end
            PH_PAYLOAD: begin
                o_result.frame_kind = c_kind;
                if (c_kind >= KIND_ARTIST && c_kind <= KIND_GENRE &&
                    c_field_count != 4'd0 && i_data[7] == 1'b0 && i_data >= TEXT_LOW) begin
                    o_result.text_valid = 1'b1;
                    o_result.text_byte  = i_data[6:0];
                end
                if (c_kind == KIND_PICTURE && c_field_count == pic_off) begin
                    o_result.picture_mark = 1'b1;
                end
                if (c_field_count != CNT_SAT) begin
                    n_field_count = cnt_inc;
                end
                n_frame_bytes_left = c_frame_bytes_left - 32'd1;
                if (n_frame_bytes_left == 32'd0) begin
                    o_result.frame_end = 1'b1;
                    n_kind             = KIND_NONE;
                    at_boundary        = 1'b1;
                end
            end

            // walk over: bytes only move the offset
            default: begin
            end
        endcase

        // next frame, end of tag or short remainder
        if (at_boundary) begin
            if (n_tag_bytes_left == 28'd0) begin
                n_phase = PH_DONE;
            end else if (n_tag_bytes_left < {24'd0, hdr_size}) begin
                n_phase = PH_STOPPED;
            end else begin
                n_phase            = PH_FRAME_HDR;
                n_field_count      = '0;
                n_frame_id         = '0;
                n_frame_bytes_left = '0;
            end
        end

        // saturating file offset
        if (c_position < OFFSET_MAX) begin
            n_position = c_position + 29'd1;
        end else begin
            n_position = c_position;
        end

        o_result.major_version = n_tag_version;
        unique case (n_phase)
            PH_NOTAG:   o_result.parse_status = ST_NO_TAG;
            PH_DONE:    o_result.parse_status = ST_FINISHED;
            PH_STOPPED: o_result.parse_status = ST_STOPPED;
            default:    o_result.parse_status = ST_WALKING;
        endcase
    end

    // a frame in payload always has bytes left
    `ASSERT_IMPLIES(a_payload_nonempty, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_frame_bytes_left != 32'd0)

    // a frame header is only started with room for the whole header
    `ASSERT_IMPLIES(a_hdr_room, i_clk, i_rst_n, r_phase == PH_FRAME_HDR, r_tag_bytes_left >= ((r_tag_version == VER_2) ? {24'd0, HDR_SIZE_V2} : {24'd0, HDR_SIZE_V3}))

    // the offset counter never passes its ceiling
    `ASSERT_HOLDS(a_offset_sat, i_clk, i_rst_n, r_position <= OFFSET_MAX)

    // text bytes only come from text frames
    `ASSERT_IMPLIES(a_text_kind, i_clk, i_rst_n, i_accept && o_result.text_valid, o_result.frame_kind >= KIND_ARTIST && o_result.frame_kind <= KIND_GENRE)

    // a finished tag stays finished until the next start of file
    `ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_phase == PH_DONE && !(i_accept && i_sof), r_phase == PH_DONE)

endmodule

// ===== hdl/id3w_out_stage.sv =====
`timescale 1ns / 1ps

module id3w_out_stage
    import id3w_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_load_ok,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // the register may take a new result when empty or being drained
    assign o_load_ok = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ok) begin
            r_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ok) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hdl/id3v2_frame_walker_unit.sv =====
`timescale 1ns / 1ps
// channel   | direction | tdata                                       | tuser / tlast
// ----------+-----------+---------------------------------------------+------------------------------
// s_axis    | in        | [7:0] data_byte                             | tuser[0] start_of_file
// m_axis    | out       | [6:0] text_byte, [35:7] byte_offset,        | tuser [3:0] frame_kind,
//           |           | [43:36] major_version, [45:44] parse_status | [4] text_valid, [5] picture_mark;
//           |           |                                             | tlast frame_end
//
// one request per clock unless m_axis stalls; each byte is parsed in the cycle it is taken and its
// result appears on m_axis in the next cycle, from a single output register.
// s_axis is ready whenever that register is empty or being taken this cycle.
// synchronous active-low reset returns the walker to the tag header phase.
// a set start_of_file bit restarts the walk on that byte.

module id3v2_frame_walker_unit
    import id3w_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,    // [0] start_of_file
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,    // text_byte, byte_offset, major_version, parse_status
    output logic [5:0]  o_m_axis_tuser,    // frame_kind, text_valid, picture_mark
    output logic        o_m_axis_tlast     // frame_end
);

    logic    accept;
    logic    load_ok;
    t_result step_result;
    t_result out_result;

    assign accept          = i_s_axis_tvalid && load_ok;
    assign o_s_axis_tready = load_ok;

    // byte parser
    id3w_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_s_axis_tdata),
        .i_sof    (i_s_axis_tuser[0]),
        .o_result (step_result)
    );

    // result register
    id3w_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_result  (step_result),
        .i_ready   (i_m_axis_tready),
        .o_load_ok (load_ok),
        .o_valid   (o_m_axis_tvalid),
        .o_result  (out_result)
    );

    // pack the result onto the stream
    assign o_m_axis_tdata = {2'b00,
                             out_result.parse_status,
                             out_result.major_version,
                             out_result.byte_offset,
                             out_result.text_byte};
    assign o_m_axis_tuser = {out_result.picture_mark,
                             out_result.text_valid,
                             out_result.frame_kind};
    assign o_m_axis_tlast = out_result.frame_end;

endmodule
